/* hw/rtl/zssf_pkg.sv */
// ----------------------------------------------------------------------------
// zssf_pkg
// Shared constants for the zlib stored-stream framer: container header bytes,
// Adler-32 modulus, stored-block limits and input action codes.
// ----------------------------------------------------------------------------
package zssf_pkg;

  // Width of the frame length and of the running byte count.
  localparam int unsigned LenW = 24;

  // Longest result burst that one input word can cause.
  localparam int unsigned BurstMax = 11;
  localparam int unsigned BurstIdxW = $clog2(BurstMax);

  // Burst lengths for the different kinds of input word.
  localparam logic [BurstIdxW:0] BurstStart   = (BurstIdxW + 1)'(7);
  localparam logic [BurstIdxW:0] BurstTrailer = (BurstIdxW + 1)'(4);
  localparam logic [BurstIdxW:0] BurstHeader  = (BurstIdxW + 1)'(5);
  localparam logic [BurstIdxW:0] BurstOne     = (BurstIdxW + 1)'(1);

  // zlib header: deflate, 32K window, no dictionary, fastest level.
  localparam logic [7:0] ZlibCmf = 8'h78;
  localparam logic [7:0] ZlibFlg = 8'h01;

  // Stored block BFINAL byte values.
  localparam logic [7:0] BlockFinal    = 8'h01;
  localparam logic [7:0] BlockNotFinal = 8'h00;

  localparam logic [15:0] BlockMax = 16'hFFFF;
  localparam logic [16:0] AdlerMod = 17'd65521;

  // Input action codes.
  localparam logic ActStart = 1'b0;
  localparam logic ActData  = 1'b1;

endpackage

/* hw/rtl/zlib_stored_stream_framer.sv */
// ----------------------------------------------------------------------------
// zlib_stored_stream_framer
// Wraps a byte stream of announced length in a zlib container built from
// stored DEFLATE blocks, with a running Adler-32 emitted as the trailer.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Ports                                        Handshake
//   in       input      in_action, in_frame_length, in_data_byte     in_valid/in_stall
//   out      output     out_byte, out_last, out_stream_end, out_error out_valid/out_stall
//
// Each accepted word is turned into a burst of 1 to 11 bytes and held in a
// burst register that drives the output one byte per cycle while out_stall is low.
// A payload word inside a block gives one byte, so payload flows at one word
// per cycle while out_stall is low; a start gives 7 or 11 bytes and a block
// boundary or frame end adds 5 or 4, and the input stalls until the burst's last byte is taken.
// A new word is accepted in the same cycle the previous burst's last byte
// leaves. Reset is synchronous and active low and closes any frame.
// ----------------------------------------------------------------------------
module zlib_stored_stream_framer (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic [zssf_pkg::LenW-1:0] in_frame_length,
  input  logic [7:0]               in_data_byte,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_byte,
  output logic                     out_last,
  output logic                     out_stream_end,
  output logic                     out_error
);

  localparam int unsigned IdxW = zssf_pkg::BurstIdxW;

  // Frame state.
  logic [15:0]               adler_low_r,   adler_low_nxt;
  logic [15:0]               adler_high_r,  adler_high_nxt;
  logic [zssf_pkg::LenW-1:0] left_total_r,  left_total_nxt;
  logic [15:0]               left_block_r,  left_block_nxt;
  logic                      frame_open_r,  frame_open_nxt;

  // Burst register.
  logic [7:0]                burst_r   [zssf_pkg::BurstMax];
  logic [7:0]                burst_nxt [zssf_pkg::BurstMax];
  logic [IdxW:0]             count_r,   count_nxt;
  logic [IdxW-1:0]           idx_r;
  logic                      valid_r;
  logic                      end_r,     end_nxt;
  logic                      err_r,     err_nxt;

  logic                      out_fire;
  logic                      last_beat;
  logic                      in_fire;

  // Datapath intermediates.
  logic [16:0]               low_sum;
  logic [15:0]               low_new;
  logic [16:0]               high_sum;
  logic [15:0]               high_new;
  logic [zssf_pkg::LenW-1:0] total_dec;
  logic [15:0]               block_dec;
  logic [zssf_pkg::LenW-1:0] hdr_total;
  logic [15:0]               hdr_len;
  logic [15:0]               hdr_nlen;
  logic [7:0]                hdr_final;
  logic [15:0]               tr_high;
  logic [15:0]               tr_low;

  assign last_beat = ({1'b0, idx_r} == count_r - (IdxW + 1)'(1));
  assign out_fire  = valid_r && !out_stall;
  assign in_stall  = valid_r && !(out_fire && last_beat);
  assign in_fire   = in_valid && !in_stall;

  assign out_valid      = valid_r;
  assign out_byte       = burst_r[idx_r];
  assign out_last       = last_beat;
  assign out_stream_end = end_r && last_beat;
  assign out_error      = err_r;

  // Adler-32 step: one conditional subtract per sum keeps both below the modulus.
  always_comb begin
    low_sum  = {1'b0, adler_low_r} + {9'd0, in_data_byte};
    low_new  = (low_sum >= zssf_pkg::AdlerMod) ? 16'(low_sum - zssf_pkg::AdlerMod)
                                               : low_sum[15:0];
    high_sum = {1'b0, adler_high_r} + {1'b0, low_new};
    high_new = (high_sum >= zssf_pkg::AdlerMod) ? 16'(high_sum - zssf_pkg::AdlerMod)
                                                : high_sum[15:0];
  end

  assign total_dec = left_total_r - zssf_pkg::LenW'(1);
  assign block_dec = left_block_r - 16'd1;

  // The block header covers what remains of the frame, at most BlockMax bytes.
  assign hdr_total = (in_action == zssf_pkg::ActStart) ? in_frame_length : total_dec;
  always_comb begin
    if (hdr_total > zssf_pkg::LenW'(zssf_pkg::BlockMax)) begin
      hdr_len   = zssf_pkg::BlockMax;
      hdr_final = zssf_pkg::BlockNotFinal;
    end else begin
      hdr_len   = hdr_total[15:0];
      hdr_final = zssf_pkg::BlockFinal;
    end
    hdr_nlen = ~hdr_len;
  end

  // An empty frame's trailer is the fresh Adler value.
  assign tr_high = (in_action == zssf_pkg::ActStart) ? 16'd0 : high_new;
  assign tr_low  = (in_action == zssf_pkg::ActStart) ? 16'd1 : low_new;

  always_comb begin
    adler_low_nxt  = adler_low_r;
    adler_high_nxt = adler_high_r;
    left_total_nxt = left_total_r;
    left_block_nxt = left_block_r;
    frame_open_nxt = frame_open_r;
    for (int i = 0; i < zssf_pkg::BurstMax; i++) begin
      burst_nxt[i] = 8'h00;
    end
    count_nxt = zssf_pkg::BurstOne;
    end_nxt   = 1'b0;
    err_nxt   = 1'b0;

    case (in_action)
      zssf_pkg::ActStart: begin
        adler_low_nxt  = 16'd1;
        adler_high_nxt = 16'd0;
        left_total_nxt = in_frame_length;
        left_block_nxt = hdr_len;
        frame_open_nxt = (in_frame_length != '0);
        burst_nxt[0] = zssf_pkg::ZlibCmf;
        burst_nxt[1] = zssf_pkg::ZlibFlg;
        burst_nxt[2] = hdr_final;
        burst_nxt[3] = hdr_len[7:0];
        burst_nxt[4] = hdr_len[15:8];
        burst_nxt[5] = hdr_nlen[7:0];
        burst_nxt[6] = hdr_nlen[15:8];
        burst_nxt[7]  = tr_high[15:8];
        burst_nxt[8]  = tr_high[7:0];
        burst_nxt[9]  = tr_low[15:8];
        burst_nxt[10] = tr_low[7:0];
        if (in_frame_length == '0) begin
          count_nxt = zssf_pkg::BurstStart + zssf_pkg::BurstTrailer;
          end_nxt   = 1'b1;
        end else begin
          count_nxt = zssf_pkg::BurstStart;
        end
      end
      zssf_pkg::ActData: begin
        if (!frame_open_r) begin
          err_nxt = 1'b1;
        end else begin
          adler_low_nxt  = low_new;
          adler_high_nxt = high_new;
          left_total_nxt = total_dec;
          left_block_nxt = block_dec;
          burst_nxt[0]   = in_data_byte;
          if (total_dec == '0) begin
            frame_open_nxt = 1'b0;
            burst_nxt[1] = tr_high[15:8];
            burst_nxt[2] = tr_high[7:0];
            burst_nxt[3] = tr_low[15:8];
            burst_nxt[4] = tr_low[7:0];
            count_nxt    = zssf_pkg::BurstOne + zssf_pkg::BurstTrailer;
            end_nxt      = 1'b1;
          end else if (block_dec == 16'd0) begin
            left_block_nxt = hdr_len;
            burst_nxt[1] = hdr_final;
            burst_nxt[2] = hdr_len[7:0];
            burst_nxt[3] = hdr_len[15:8];
            burst_nxt[4] = hdr_nlen[7:0];
            burst_nxt[5] = hdr_nlen[15:8];
            count_nxt    = zssf_pkg::BurstOne + zssf_pkg::BurstHeader;
          end
        end
      end
      default: begin
        err_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adler_low_r  <= 16'd1;
      adler_high_r <= 16'd0;
      left_total_r <= '0;
      left_block_r <= 16'd0;
      frame_open_r <= 1'b0;
      valid_r      <= 1'b0;
      idx_r        <= '0;
    end else if (in_fire) begin
      adler_low_r  <= adler_low_nxt;
      adler_high_r <= adler_high_nxt;
      left_total_r <= left_total_nxt;
      left_block_r <= left_block_nxt;
      frame_open_r <= frame_open_nxt;
      valid_r      <= 1'b1;
      idx_r        <= '0;
    end else if (out_fire) begin
      if (last_beat) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IdxW'(1);
      end
    end
  end

  // Burst payload needs no reset; it is qualified by valid_r.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      burst_r <= burst_nxt;
      count_r <= count_nxt;
      end_r   <= end_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule
